// ===== design/multi_axis_step_dir_generator_core_assert.svh =====
// Assertion macros shared by the step/dir generator RTL.
// Plain text macros, no dependencies; included inside module bodies.
`ifndef MULTI_AXIS_STEP_DIR_GENERATOR_CORE_ASSERT_SVH
`define MULTI_AXIS_STEP_DIR_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MSDG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("step/dir generator: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define MSDG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("step/dir generator: next-cycle check failed");

`endif

// ===== design/msdg_pkg.sv =====
// Package for the multi-axis step/dir generator: widths, codes, constants
// and the structs that pass between the top level and the motor slices.
package msdg_pkg;

  localparam int NumMotorsDef = 5;
  localparam int NumSpeedRegs = 5;
  localparam int ImageW       = 24;
  localparam int PinIdxW      = 5;
  localparam int TimeW        = 32;
  localparam int CountW       = 32;
  localparam int SpeedW       = 6;
  localparam int MaskW        = 5;
  localparam int DataW        = 32;
  localparam int AddrW        = 5;
  localparam int RegIdxW      = 3;

  localparam logic [SpeedW-1:0]  MaxDelay   = 6'd50;
  localparam logic [TimeW-1:0]   PsLow      = 32'd1000;
  localparam logic [TimeW-1:0]   PsHigh     = 32'd2000;
  localparam logic [ImageW-1:0]  ResetImage = 24'h00FFFF;
  localparam logic [PinIdxW-1:0] LastPin    = 5'd23;

  typedef enum logic [1:0] {
    ActService = 2'd0,
    ActMove    = 2'd1,
    ActSetPin  = 2'd2
  } action_e;

  // Register indexes; speed registers occupy 0 .. NumSpeedRegs-1.
  localparam logic [RegIdxW-1:0] RegPowersave = 3'd5;
  localparam logic [RegIdxW-1:0] RegInvertDir = 3'd6;

  typedef logic [SpeedW-1:0] speed_t;

  typedef struct packed {
    logic              svc;
    logic              load;
    logic [CountW-1:0] cnt;
    logic [TimeW-1:0]  now;
    speed_t            speed;
    logic              ps_en;
    logic              inv;
    logic              latched_en;
  } motor_cmd_t;

  typedef struct packed {
    logic stepped;
    logic dir;
    logic en_raise;
  } motor_stat_t;

endpackage

// ===== design/multi_axis_step_dir_generator_core.sv =====
// Top level of the multi-axis step/dir generator: input register, image logic,
// motor slices, config registers and result buffer. Depends on msdg_pkg,
// msdg_cfg, msdg_motor, msdg_outbuf and the assertion macro header.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid_i/in_stall_o action, now_ms, motor, step_count,
//                                             pin, pin_value
//   out      source     out_valid_o/out_stall_i pin_image, last
//   cfg      APB        psel/penable/pready   paddr, pwdata, prdata
//
// An accepted item is held in the input register; when it proceeds, the state
// registers take it and, for a service item that changed the image, the result
// pair is loaded. The pair buffer hands the pair out as two items; moves and pin
// writes run at one per cycle unless a service item held ahead of them stalls
// the input. A service item waits in the input register while the buffer still
// holds an earlier pair. Reset is asynchronous, active low, and brings the image
// to pins 0..15 high with every motor idle.
module multi_axis_step_dir_generator_core #(
  parameter int NUM_MOTORS = msdg_pkg::NumMotorsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [msdg_pkg::TimeW-1:0]    now_ms_i,
  input  logic [2:0]                    motor_i,
  input  logic signed [msdg_pkg::CountW-1:0] step_count_i,
  input  logic [msdg_pkg::PinIdxW-1:0]  pin_i,
  input  logic                          pin_value_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [msdg_pkg::ImageW-1:0]   pin_image_o,
  output logic                          last_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msdg_pkg::AddrW-1:0]    paddr,
  input  logic [msdg_pkg::DataW-1:0]    pwdata,
  output logic [msdg_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import msdg_pkg::*;
  `include "multi_axis_step_dir_generator_core_assert.svh"

  // Input register.
  logic                in_valid_q;
  logic [1:0]          action_q;
  logic [TimeW-1:0]    now_q;
  logic [2:0]          motor_q;
  logic [CountW-1:0]   count_q;
  logic [PinIdxW-1:0]  pin_q;
  logic                pin_value_q;
  logic                in_fire;
  logic                proc_fire;
  logic                out_free;

  // Image state.
  logic [ImageW-1:0]   working_q, working_d;
  logic [ImageW-1:0]   latched_q, latched_d;
  logic                changed_q, changed_d;
  logic [ImageW-1:0]   svc_image;
  logic [ImageW-1:0]   step_mask;
  logic                svc_touch;
  logic                pair_load;

  // Configuration.
  speed_t              speed_cfg [NumSpeedRegs];
  logic [MaskW-1:0]    ps_mask;
  logic [MaskW-1:0]    inv_mask;

  motor_cmd_t          mcmd  [NUM_MOTORS];
  motor_stat_t         mstat [NUM_MOTORS];

  // A service item needs the result buffer; other items go straight through.
  assign proc_fire  = in_valid_q && (action_q != ActService || out_free);
  assign in_stall_o = in_valid_q && !proc_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q    <= action_i;
      now_q       <= now_ms_i;
      motor_q     <= motor_i;
      count_q     <= step_count_i;
      pin_q       <= pin_i;
      pin_value_q <= pin_value_i;
    end
  end

  msdg_cfg #(
    .NUM_MOTORS (NUM_MOTORS)
  ) u_cfg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .speed_o           (speed_cfg),
    .powersave_mask_o  (ps_mask),
    .invert_dir_mask_o (inv_mask)
  );

  // One slice per motor; motors past the configured five run at full speed
  // with powersave and inversion off.
  for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_motor
    assign mcmd[m].svc        = proc_fire && action_q == ActService;
    assign mcmd[m].load       = proc_fire && action_q == ActMove && motor_q == 3'(m);
    assign mcmd[m].cnt        = count_q;
    assign mcmd[m].now        = now_q;
    assign mcmd[m].latched_en = latched_q[3*m];
    if (m < NumSpeedRegs) begin : g_cfg
      assign mcmd[m].speed = speed_cfg[m];
      assign mcmd[m].ps_en = ps_mask[m];
      assign mcmd[m].inv   = inv_mask[m];
    end else begin : g_nocfg
      assign mcmd[m].speed = MaxDelay;
      assign mcmd[m].ps_en = 1'b0;
      assign mcmd[m].inv   = 1'b0;
    end

    msdg_motor u_motor (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (mcmd[m]),
      .stat_o (mstat[m])
    );
  end

  // Image after servicing every motor, plus the step pins of all motors.
  // Any step or enable raise counts as a change, even when no bit moves.
  always_comb begin
    svc_image = working_q;
    step_mask = '0;
    svc_touch = 1'b0;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      step_mask[3*m+1] = 1'b1;
      if (mstat[m].stepped) begin
        svc_image[3*m+2] = mstat[m].dir;
        svc_image[3*m+1] = 1'b0;
        svc_touch        = 1'b1;
      end
      if (mstat[m].en_raise) begin
        svc_image[3*m] = 1'b1;
        svc_touch      = 1'b1;
      end
    end
  end

  always_comb begin
    working_d = working_q;
    latched_d = latched_q;
    changed_d = changed_q;
    pair_load = 1'b0;
    if (proc_fire) begin
      unique case (action_q)
        ActService: begin
          // Any motor activity or an earlier command marks the image dirty.
          if (changed_q || svc_touch) begin
            pair_load = 1'b1;
            working_d = svc_image | step_mask;
            latched_d = svc_image | step_mask;
            changed_d = 1'b0;
          end
        end
        ActMove: begin
          // Enable pin low turns the driver on; unknown motors are dropped.
          if (32'(motor_q) < NUM_MOTORS) begin
            working_d[PinIdxW'(3 * 32'(motor_q))] = 1'b0;
            changed_d = 1'b1;
          end
        end
        ActSetPin: begin
          if (pin_q <= LastPin) working_d[pin_q] = pin_value_q;
          changed_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      working_q <= ResetImage;
      latched_q <= '0;
      changed_q <= 1'b0;
    end else begin
      working_q <= working_d;
      latched_q <= latched_d;
      changed_q <= changed_d;
    end
  end

  msdg_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (pair_load),
    .first_img_i  (svc_image),
    .second_img_i (svc_image | step_mask),
    .free_o       (out_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pin_image_o  (pin_image_o),
    .last_o       (last_o)
  );

  // A first image taken by the sink is always followed by its partner.
  `MSDG_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni,
                    out_valid_o && !out_stall_i && !last_o, out_valid_o && last_o)
  // The second image of a pair carries every step pin high.
  `MSDG_ASSERT_NOW(a_steps_high, clk_i, rst_ni,
                   out_valid_o && last_o, (pin_image_o & step_mask) == step_mask)
  // Emitting a pair leaves the image clean and latched.
  `MSDG_ASSERT_NEXT(a_clean_after, clk_i, rst_ni, pair_load,
                    !changed_q && latched_q == working_q)
  // A held item stays in the input register.
  `MSDG_ASSERT_NEXT(a_hold_input, clk_i, rst_ni, in_valid_q && !proc_fire, in_valid_q)

endmodule

// ===== design/msdg_cfg.sv =====
// APB-style configuration registers: five speeds and two per-motor masks.
// Depends on msdg_pkg.
module msdg_cfg #(
  parameter int NUM_MOTORS = msdg_pkg::NumMotorsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msdg_pkg::AddrW-1:0]    paddr,
  input  logic [msdg_pkg::DataW-1:0]    pwdata,
  output logic [msdg_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output msdg_pkg::speed_t              speed_o [msdg_pkg::NumSpeedRegs],
  output logic [msdg_pkg::MaskW-1:0]    powersave_mask_o,
  output logic [msdg_pkg::MaskW-1:0]    invert_dir_mask_o
);
  import msdg_pkg::*;

  speed_t             speed_q [NumSpeedRegs];
  logic [MaskW-1:0]   ps_mask_q;
  logic [MaskW-1:0]   inv_mask_q;
  logic               wr_en;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSpeedRegs; i++) speed_q[i] <= MaxDelay;
      ps_mask_q  <= '1;
      inv_mask_q <= '0;
    end else if (wr_en) begin
      for (int i = 0; i < NumSpeedRegs; i++) begin
        if (i < NUM_MOTORS && reg_idx == RegIdxW'(i)) speed_q[i] <= pwdata[SpeedW-1:0];
      end
      if (reg_idx == RegPowersave) ps_mask_q  <= pwdata[MaskW-1:0];
      if (reg_idx == RegInvertDir) inv_mask_q <= pwdata[MaskW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < NumSpeedRegs; i++) begin
      if (reg_idx == RegIdxW'(i)) prdata = DataW'(speed_q[i]);
    end
    if (reg_idx == RegPowersave) prdata = DataW'(ps_mask_q);
    if (reg_idx == RegInvertDir) prdata = DataW'(inv_mask_q);
  end

  assign speed_o           = speed_q;
  assign powersave_mask_o  = ps_mask_q;
  assign invert_dir_mask_o = inv_mask_q;

endmodule

// ===== design/msdg_motor.sv =====
// One motor slice: step counter, due time, step decision and powersave window.
// Depends on msdg_pkg.
module msdg_motor (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  msdg_pkg::motor_cmd_t cmd_i,
  output msdg_pkg::motor_stat_t stat_o
);
  import msdg_pkg::*;

  logic [CountW-1:0] steps_q, steps_d;
  logic [TimeW-1:0]  due_q, due_d;
  logic              due_hit;
  logic              stepped;
  logic [SpeedW-1:0] delay;
  logic [TimeW-1:0]  new_due;
  logic [TimeW-1:0]  due_eff;
  logic [TimeW-1:0]  win_lo;
  logic [TimeW-1:0]  win_hi;

  assign due_hit = cmd_i.now >= due_q;
  assign stepped = due_hit && (steps_q != '0);
  // Speeds above the maximum mean zero delay.
  assign delay   = (cmd_i.speed > MaxDelay) ? '0 : MaxDelay - cmd_i.speed;
  assign new_due = cmd_i.now + TimeW'(delay);
  assign due_eff = stepped ? new_due : due_q;
  assign win_lo  = due_eff + PsLow;
  assign win_hi  = due_eff + PsHigh;

  always_comb begin
    steps_d = steps_q;
    due_d   = due_q;
    if (cmd_i.load) begin
      steps_d = cmd_i.cnt;
    end else if (cmd_i.svc && stepped) begin
      // Count toward zero from either side.
      steps_d = steps_q[CountW-1] ? steps_q + 1'b1 : steps_q - 1'b1;
      due_d   = new_due;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
      due_q   <= '0;
    end else begin
      steps_q <= steps_d;
      due_q   <= due_d;
    end
  end

  assign stat_o.stepped  = stepped;
  assign stat_o.dir      = ~steps_q[CountW-1] ^ cmd_i.inv;
  assign stat_o.en_raise = due_hit && cmd_i.ps_en && (cmd_i.now >= win_lo) &&
                           (cmd_i.now <= win_hi) && !cmd_i.latched_en;

endmodule

// ===== design/msdg_outbuf.sv =====
// Result buffer: holds the image pair of one service item and hands it out
// as two items, first image then step-high image. Depends on msdg_pkg.
module msdg_outbuf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [msdg_pkg::ImageW-1:0] first_img_i,
  input  logic [msdg_pkg::ImageW-1:0] second_img_i,
  output logic                        free_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [msdg_pkg::ImageW-1:0] pin_image_o,
  output logic                        last_o
);
  import msdg_pkg::*;

  logic              out_valid_q;
  logic              out_last_q;
  logic [ImageW-1:0] out_img_q;
  logic              pend_valid_q;
  logic [ImageW-1:0] pend_img_q;
  logic              out_fire;

  assign out_fire = out_valid_q & ~out_stall_i;
  assign free_o   = ~out_valid_q | (out_fire & ~pend_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q  <= 1'b1;
      out_last_q   <= 1'b0;
      pend_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q  <= pend_valid_q;
      out_last_q   <= 1'b1;
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_img_q  <= first_img_i;
      pend_img_q <= second_img_i;
    end else if (out_fire && pend_valid_q) begin
      out_img_q <= pend_img_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pin_image_o = out_img_q;
  assign last_o      = out_last_q;

endmodule
